/* design/spm_pkg.sv */
`timescale 1ns / 1ps
package spm_pkg;
	typedef struct packed {
		logic [23:0] utterance_length;
		logic [15:0] band_zero;
		logic [15:0] band_one;
		logic [15:0] band_two;
		logic [15:0] band_three;
		logic        override_valid;
		logic [3:0]  override_tag;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  speaker_tag;
		logic [16:0] confidence;
		logic [2:0]  outcome;
	} out_item_t;

	localparam logic [2:0] OUT_FALLBACK = 3'd0;
	localparam logic [2:0] OUT_OVERRIDE = 3'd1;
	localparam logic [2:0] OUT_MATCHED  = 3'd2;
	localparam logic [2:0] OUT_ENROLLED = 3'd3;
	localparam logic [2:0] OUT_PINNED   = 3'd4;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_MAX_SPK   = 2'd1;
	localparam logic [1:0] REG_MIN_SAMP  = 2'd2;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	typedef enum logic [1:0] {
		DOP_DIV,
		DOP_SQRT
	} div_op_t;

	typedef struct packed {
		logic    start;
		div_op_t op;
	} div_ctl_t;
endpackage

/* design/spm_cfg.sv */
`timescale 1ns / 1ps
module spm_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [16:0] match_threshold,
	output logic [2:0]  max_speakers,
	output logic [23:0] min_samples
);
	logic [16:0] thr_q;
	logic [2:0]  cap_q;
	logic [23:0] min_q;
	logic [1:0]  idx;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 17'd49152;
			cap_q <= 3'd2;
			min_q <= 24'd8000;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				spm_pkg::REG_THRESHOLD: thr_q <= pwdata[16:0];
				spm_pkg::REG_MAX_SPK:   cap_q <= pwdata[2:0];
				spm_pkg::REG_MIN_SAMP:  min_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			spm_pkg::REG_THRESHOLD: prdata = {15'd0, thr_q};
			spm_pkg::REG_MAX_SPK:   prdata = {29'd0, cap_q};
			spm_pkg::REG_MIN_SAMP:  prdata = {8'd0, min_q};
			default:                prdata = 32'd0;
		endcase
	end

	assign match_threshold = thr_q;
	assign max_speakers    = cap_q;
	assign min_samples     = min_q;
endmodule

/* design/spm_divsqrt.sv */
`timescale 1ns / 1ps
module spm_divsqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  spm_pkg::div_ctl_t ctl,
	input  logic [47:0]      num,
	input  logic [31:0]      den,
	output logic             done,
	output logic [47:0]      res
);
	logic [47:0] n_q;
	logic [48:0] rem_q;
	logic [47:0] q_q;
	logic [31:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        sq_q;
	logic [48:0] rem_sh;
	logic [48:0] trial;
	logic [49:0] s_rem;
	logic [49:0] s_trial;

	assign rem_sh  = {rem_q[47:0], n_q[47]};
	assign trial   = {17'd0, d_q};
	assign s_rem   = {rem_q[47:0], n_q[47:46]};
	assign s_trial = {q_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				sq_q   <= (ctl.op == spm_pkg::DOP_SQRT);
				n_q    <= num;
				d_q    <= den;
				rem_q  <= '0;
				q_q    <= '0;
				cnt_q  <= (ctl.op == spm_pkg::DOP_SQRT) ? 6'd24 : 6'd48;
			end else if (busy_q) begin
				if (sq_q) begin
					n_q <= {n_q[45:0], 2'b00};
					if (s_rem >= s_trial) begin
						rem_q <= 49'(s_rem - s_trial);
						q_q   <= {q_q[46:0], 1'b1};
					end else begin
						rem_q <= s_rem[48:0];
						q_q   <= {q_q[46:0], 1'b0};
					end
				end else begin
					n_q <= {n_q[46:0], 1'b0};
					if (rem_sh >= trial) begin
						rem_q <= rem_sh - trial;
						q_q   <= {q_q[46:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						q_q   <= {q_q[46:0], 1'b0};
					end
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign res = q_q;
endmodule

/* design/speaker_profile_matcher_core.sv */
`timescale 1ns / 1ps
// Online nearest-centroid speaker matcher. A short utterance without override skips
// scoring and goes straight to the output as a fallback. Otherwise each stored profile is
// scored in turn, and the override tag search and the stale search take one profile per
// cycle. Training a profile runs four 48-step divisions for the running average, four
// squarings, a 24-step square root and, unless that root is zero, four more divisions
// for renormalization, all on one shared radix-2 unit.
// in_stall is high while an item is in work; a finished result waits in the output
// register, and the next result waits in its final state until that register is taken.
module speaker_profile_matcher_core #(
	parameter int MAX_PROFILES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  spm_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output spm_pkg::out_item_t  out_data
);
	localparam int IW = (MAX_PROFILES > 1) ? $clog2(MAX_PROFILES) : 1;
	localparam int CW = $clog2(MAX_PROFILES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_TAGS, S_STALE, S_DECIDE, S_AVG, S_AVGW,
		S_SQ, S_SQRT, S_SQRTW, S_NRM, S_NRMW, S_OUT
	} state_t;

	logic [16:0] thr;
	logic [2:0]  max_spk;
	logic [23:0] min_samp;

	spm_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.match_threshold(thr), .max_speakers(max_spk), .min_samples(min_samp)
	);

	state_t      state_q;
	logic [CW-1:0] count_q;
	logic [3:0]  ptag_q [MAX_PROFILES];
	logic [15:0] cen_q  [MAX_PROFILES][4];
	logic [15:0] scnt_q [MAX_PROFILES];
	logic [31:0] seen_q [MAX_PROFILES];
	logic [31:0] stamp_q;
	logic [3:0]  ltag_q;
	logic [16:0] lconf_q;

	spm_pkg::in_item_t it_q;
	spm_pkg::out_item_t res_q;
	logic        out_valid_q;
	logic [15:0] f_q [4];
	logic [CW-1:0] i_q;
	logic [IW-1:0] best_q, idx_q, st_q;
	logic [16:0] bsim_q;
	logic        have_q, found_q;
	logic [1:0]  b_q;
	logic [31:0] t_q [4];
	logic [47:0] sq_q;
	logic [31:0] norm_q;
	logic [CW-1:0] cap;
	logic [31:0] prod_s1;
	logic [33:0] dot_q;

	spm_pkg::div_ctl_t dctl;
	logic [47:0] dnum;
	logic [31:0] dden;
	logic        ddone;
	logic [47:0] dres;

	spm_divsqrt u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .num(dnum), .den(dden),
		.done(ddone), .res(dres)
	);

	always_comb begin
		if (max_spk == 3'd0) cap = CW'(1);
		else if (32'(max_spk) > MAX_PROFILES) cap = CW'(MAX_PROFILES);
		else cap = CW'(max_spk);
	end

	logic [IW-1:0] ii;
	logic [15:0]   cn;
	logic [16:0]   dd;
	logic [16:0]   sim;
	logic [33:0]   dsum;
	assign ii  = i_q[IW-1:0];
	assign cn  = scnt_q[idx_q];
	assign dd  = {1'b0, cn} + 17'd1;
	assign dsum = dot_q + 34'(prod_s1);
	assign sim = (dsum[33:16] > 18'd65536) ? spm_pkg::ONE_Q16 : dsum[32:16];

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		dctl.start = 1'b0;
		dctl.op    = spm_pkg::DOP_DIV;
		dnum = '0;
		dden = '0;
		if (state_q == S_AVG) begin
			dctl.start = 1'b1;
			dnum = 48'(cen_q[idx_q][b_q]) * 48'(cn) + 48'(f_q[b_q]) + 48'(dd >> 1);
			dden = 32'(dd);
		end else if (state_q == S_SQRT) begin
			dctl.start = 1'b1;
			dctl.op = spm_pkg::DOP_SQRT;
			dnum = sq_q;
		end else if (state_q == S_NRM) begin
			dctl.start = 1'b1;
			dnum = {t_q[b_q], 16'd0} + 48'(norm_q >> 1);
			dden = norm_q;
		end
	end

	logic [2:0] sub_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			stamp_q <= '0;
			ltag_q  <= '0;
			lconf_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					it_q <= in_data;
					f_q[0] <= in_data.band_zero;
					f_q[1] <= in_data.band_one;
					f_q[2] <= in_data.band_two;
					f_q[3] <= in_data.band_three;
					stamp_q <= stamp_q + 32'd1;
					if (in_data.utterance_length < min_samp && !in_data.override_valid) begin
						res_q <= '{ltag_q, lconf_q, spm_pkg::OUT_FALLBACK};
						state_q <= S_OUT;
					end else begin
						i_q <= '0; have_q <= 1'b0; best_q <= '0; bsim_q <= '0;
						sub_q <= '0; dot_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (i_q >= count_q) begin
						i_q <= '0; found_q <= 1'b0; idx_q <= '0;
						state_q <= S_TAGS;
					end else begin
						if (sub_q != 3'd0) dot_q <= dsum;
						if (sub_q < 3'd4) begin
							prod_s1 <= f_q[sub_q[1:0]] * cen_q[ii][sub_q[1:0]];
							if (sub_q == 3'd0) dot_q <= '0;
							sub_q <= sub_q + 3'd1;
						end else begin
							if (!have_q || sim > bsim_q) begin
								have_q <= 1'b1; bsim_q <= sim; best_q <= ii;
							end
							sub_q <= '0;
							i_q <= i_q + CW'(1);
						end
					end
				end
				S_TAGS: begin
					if (i_q >= count_q || found_q || !it_q.override_valid) begin
						i_q <= CW'(1); st_q <= '0;
						state_q <= S_STALE;
					end else begin
						if (ptag_q[ii] == it_q.override_tag) begin
							found_q <= 1'b1; idx_q <= ii;
						end
						i_q <= i_q + CW'(1);
					end
				end
				S_STALE: begin
					if (i_q >= count_q) state_q <= S_DECIDE;
					else begin
						if (seen_q[ii] < seen_q[st_q]) st_q <= ii;
						i_q <= i_q + CW'(1);
					end
				end
				S_DECIDE: begin
					b_q <= '0;
					if (it_q.override_valid) begin
						res_q <= '{it_q.override_tag, spm_pkg::ONE_Q16,
							spm_pkg::OUT_OVERRIDE};
						ltag_q <= it_q.override_tag; lconf_q <= spm_pkg::ONE_Q16;
						if (found_q) state_q <= S_AVG;
						else begin
							logic [IW-1:0] w;
							state_q <= S_OUT;
							w = (count_q < cap) ? count_q[IW-1:0] : st_q;
							if (count_q < cap) count_q <= count_q + CW'(1);
							ptag_q[w] <= it_q.override_tag;
							for (int k = 0; k < 4; k++) cen_q[w][k] <= f_q[k];
							scnt_q[w] <= 16'd1; seen_q[w] <= stamp_q;
						end
					end else if (have_q && bsim_q >= thr) begin
						res_q <= '{ptag_q[best_q], bsim_q, spm_pkg::OUT_MATCHED};
						ltag_q <= ptag_q[best_q]; lconf_q <= bsim_q;
						idx_q <= best_q;
						state_q <= S_AVG;
					end else if (count_q < cap) begin
						res_q <= '{4'(count_q), spm_pkg::ONE_Q16, spm_pkg::OUT_ENROLLED};
						ltag_q <= 4'(count_q); lconf_q <= spm_pkg::ONE_Q16;
						ptag_q[count_q[IW-1:0]] <= 4'(count_q);
						for (int k = 0; k < 4; k++) cen_q[count_q[IW-1:0]][k] <= f_q[k];
						scnt_q[count_q[IW-1:0]] <= 16'd1;
						seen_q[count_q[IW-1:0]] <= stamp_q;
						count_q <= count_q + CW'(1);
						state_q <= S_OUT;
					end else begin
						res_q <= '{ptag_q[best_q], bsim_q, spm_pkg::OUT_PINNED};
						ltag_q <= ptag_q[best_q]; lconf_q <= bsim_q;
						state_q <= S_OUT;
					end
				end
				S_AVG: state_q <= S_AVGW;
				S_AVGW: if (ddone) begin
					t_q[b_q] <= dres[31:0];
					b_q <= b_q + 2'd1;
					if (b_q == 2'd3) begin
						sq_q <= '0; state_q <= S_SQ;
					end else state_q <= S_AVG;
				end
				S_SQ: begin
					sq_q <= sq_q + 48'(t_q[b_q][15:0]) * 48'(t_q[b_q][15:0]);
					b_q <= b_q + 2'd1;
					if (b_q == 2'd3) state_q <= S_SQRT;
				end
				S_SQRT: state_q <= S_SQRTW;
				S_SQRTW: if (ddone) begin
					norm_q <= dres[31:0];
					b_q <= '0;
					if (dres == '0) begin
						for (int k = 0; k < 4; k++) cen_q[idx_q][k] <= '0;
						if (cn != 16'hFFFF) scnt_q[idx_q] <= cn + 16'd1;
						seen_q[idx_q] <= stamp_q;
						state_q <= S_OUT;
					end else state_q <= S_NRM;
				end
				S_NRM: state_q <= S_NRMW;
				S_NRMW: if (ddone) begin
					cen_q[idx_q][b_q] <= (dres > 48'd65535) ? 16'hFFFF : dres[15:0];
					b_q <= b_q + 2'd1;
					if (b_q == 2'd3) begin
						if (cn != 16'hFFFF) scnt_q[idx_q] <= cn + 16'd1;
						seen_q[idx_q] <= stamp_q;
						state_q <= S_OUT;
					end else state_q <= S_NRM;
				end
				S_OUT: if (!out_valid_q || !out_stall) begin
					out_data <= res_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_OUT && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end
endmodule

/* bench/tb_speaker_profile_matcher_core.sv */
`timescale 1ns / 1ps
module tb_speaker_profile_matcher_core;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	spm_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	spm_pkg::out_item_t out_data;

	speaker_profile_matcher_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [16:0] thr_q;
	logic [2:0] cap_reg;
	logic [23:0] min_len;
	int unsigned nprof;
	logic [3:0] ptag [4];
	logic [15:0] cent [4][4];
	logic [15:0] pcount [4];
	logic [31:0] seen [4];
	logic [31:0] stamp;
	logic [3:0] prev_tag;
	logic prev_known;
	logic [16:0] prev_conf;

	spm_pkg::in_item_t pending_items [$];
	spm_pkg::out_item_t expected_results [$];
	int mismatches = 0;
	int n_results = 0;
	int n_sent = 0;
	bit hold_sender = 1'b0;
	int outcome_seen [5];

	function automatic logic [16:0] sim_of(spm_pkg::in_item_t it, int p);
		logic [63:0] dot;
		dot = 64'(it.band_zero) * cent[p][0] + 64'(it.band_one) * cent[p][1]
			+ 64'(it.band_two) * cent[p][2] + 64'(it.band_three) * cent[p][3];
		dot = dot >> 16;
		return (dot > 64'd65536) ? 17'd65536 : dot[16:0];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic store_profile(int p, logic [3:0] tag, logic [15:0] f [4]);
		ptag[p] = tag;
		for (int b = 0; b < 4; b++) cent[p][b] = f[b];
		pcount[p] = 16'd1;
		seen[p] = stamp;
	endtask

	task automatic train(int p, logic [15:0] f [4]);
		logic [63:0] n, d, sq, nrm, v;
		logic [63:0] t [4];
		n = pcount[p];
		d = n + 1;
		sq = 0;
		for (int b = 0; b < 4; b++) begin
			t[b] = (64'(cent[p][b]) * n + f[b] + d / 2) / d;
			sq += t[b] * t[b];
		end
		nrm = int_sqrt(sq);
		for (int b = 0; b < 4; b++) begin
			v = 0;
			if (nrm != 0) v = (t[b] * 65536 + nrm / 2) / nrm;
			cent[p][b] = (v > 65535) ? 16'hFFFF : v[15:0];
		end
		if (pcount[p] != 16'hFFFF) pcount[p]++;
		seen[p] = stamp;
	endtask

	task automatic predict_match(spm_pkg::in_item_t it);
		logic [15:0] f [4];
		int unsigned cap, best, st;
		logic [16:0] best_sim, s, conf;
		logic have, found;
		int idx;
		logic [3:0] tag;
		logic [2:0] oc;
		spm_pkg::out_item_t r;
		f[0] = it.band_zero; f[1] = it.band_one;
		f[2] = it.band_two; f[3] = it.band_three;
		stamp = stamp + 1;
		cap = (cap_reg < 1) ? 1 : (cap_reg > 4) ? 4 : cap_reg;
		if (it.utterance_length < min_len && !it.override_valid) begin
			tag = prev_known ? prev_tag : 4'd0;
			prev_tag = tag;
			prev_known = 1'b1;
			r.speaker_tag = tag;
			r.confidence = prev_conf;
			r.outcome = spm_pkg::OUT_FALLBACK;
			expected_results.push_back(r);
			return;
		end
		have = 0; best = 0; best_sim = 0;
		for (int i = 0; i < nprof; i++) begin
			s = sim_of(it, i);
			if (!have || s > best_sim) begin
				have = 1; best_sim = s; best = i;
			end
		end
		if (it.override_valid) begin
			found = 0; idx = 0;
			for (int i = 0; i < nprof; i++)
				if (!found && ptag[i] == it.override_tag) begin
					found = 1; idx = i;
				end
			if (found) train(idx, f);
			else if (nprof < cap) begin
				store_profile(nprof, it.override_tag, f);
				nprof++;
			end else begin
				st = 0;
				for (int i = 1; i < nprof; i++) if (seen[i] < seen[st]) st = i;
				store_profile(st, it.override_tag, f);
			end
			tag = it.override_tag; conf = spm_pkg::ONE_Q16; oc = spm_pkg::OUT_OVERRIDE;
		end else if (have && best_sim >= thr_q) begin
			tag = ptag[best];
			train(best, f);
			conf = best_sim; oc = spm_pkg::OUT_MATCHED;
		end else if (nprof < cap) begin
			tag = 4'(nprof);
			store_profile(nprof, tag, f);
			nprof++;
			conf = spm_pkg::ONE_Q16; oc = spm_pkg::OUT_ENROLLED;
		end else begin
			tag = ptag[best]; conf = best_sim; oc = spm_pkg::OUT_PINNED;
		end
		prev_tag = tag;
		prev_known = 1'b1;
		prev_conf = conf;
		r.speaker_tag = tag;
		r.confidence = conf;
		r.outcome = oc;
		expected_results.push_back(r);
	endtask

	// unit-ish fingerprint around a few base voices, random perturbation
	function automatic spm_pkg::in_item_t make_voice(int v, int spread);
		spm_pkg::in_item_t it;
		logic [15:0] base [4];
		int x;
		case (v % 4)
			0: base = '{16'd60000, 16'd20000, 16'd12000, 16'd8000};
			1: base = '{16'd10000, 16'd58000, 16'd25000, 16'd9000};
			2: base = '{16'd9000, 16'd15000, 16'd60000, 16'd18000};
			default: base = '{16'd12000, 16'd8000, 16'd20000, 16'd61000};
		endcase
		x = int'(base[0]) + $urandom_range(0, 2 * spread) - spread;
		it.band_zero = (x < 0) ? 16'd0 : (x > 65535) ? 16'hFFFF : x[15:0];
		x = int'(base[1]) + $urandom_range(0, 2 * spread) - spread;
		it.band_one = (x < 0) ? 16'd0 : (x > 65535) ? 16'hFFFF : x[15:0];
		x = int'(base[2]) + $urandom_range(0, 2 * spread) - spread;
		it.band_two = (x < 0) ? 16'd0 : (x > 65535) ? 16'hFFFF : x[15:0];
		x = int'(base[3]) + $urandom_range(0, 2 * spread) - spread;
		it.band_three = (x < 0) ? 16'd0 : (x > 65535) ? 16'hFFFF : x[15:0];
		it.utterance_length = 24'($urandom_range(8000, 400000));
		it.override_valid = 1'b0;
		it.override_tag = 4'($urandom_range(0, 15));
		return it;
	endfunction

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			spm_pkg::REG_THRESHOLD: thr_q = val[16:0];
			spm_pkg::REG_MAX_SPK: cap_reg = val[2:0];
			default: min_len = val[23:0];
		endcase
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// driver
	int gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_match(in_data);
				n_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0 && !hold_sender) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
					gap = ($urandom_range(0, 9) < 6) ? 0 :
						($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 120);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int stall_len = 0;
	always @(posedge clk) begin
		spm_pkg::out_item_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: tag=%0d conf=%0d outcome=%0d",
							out_data.speaker_tag, out_data.confidence, out_data.outcome);
				end else begin
					e = expected_results.pop_front();
					if (e.outcome <= spm_pkg::OUT_PINNED) outcome_seen[e.outcome]++;
					if (out_data.speaker_tag !== e.speaker_tag ||
						out_data.confidence !== e.confidence ||
						out_data.outcome !== e.outcome) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch #%0d: exp tag=%0d conf=%0d outcome=%0d, ",
								"got tag=%0d conf=%0d outcome=%0d"},
								n_results, e.speaker_tag, e.confidence, e.outcome,
								out_data.speaker_tag, out_data.confidence, out_data.outcome);
					end
				end
			end
			if (stall_len > 0) begin
				stall_len--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 9) < 3) begin
				stall_len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 150);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic add_voices(int count, int novr);
		spm_pkg::in_item_t it;
		for (int k = 0; k < count; k++) begin
			it = make_voice($urandom_range(0, 5), $urandom_range(0, 9) < 7 ? 3000 : 20000);
			case ($urandom_range(0, 9))
				0: it.utterance_length = 24'($urandom_range(0, 7999));
				1: begin
					it = '0;
					it.utterance_length = 24'($urandom);
					it.band_zero = 16'($urandom); it.band_one = 16'($urandom);
					it.band_two = 16'($urandom); it.band_three = 16'($urandom);
				end
				default: ;
			endcase
			if ($urandom_range(0, 99) < novr) begin
				it.override_valid = 1'b1;
				it.override_tag = 4'($urandom_range(0, 15));
			end
			pending_items.push_back(it);
		end
	endtask

	initial begin
		spm_pkg::in_item_t it;
		thr_q = 17'd49152; cap_reg = 3'd2; min_len = 24'd8000;
		nprof = 0; stamp = 0; prev_tag = 0; prev_known = 0; prev_conf = 0;
		for (int p = 0; p < 4; p++) begin
			ptag[p] = 0; pcount[p] = 0; seen[p] = 0;
			for (int b = 0; b < 4; b++) cent[p][b] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: fallback before anything known, extremes, enroll, match, pin, overrides
		it = '0;
		pending_items.push_back(it);
		it.utterance_length = 24'hFFFFFF;
		it.band_zero = 16'hFFFF; it.band_one = 16'hFFFF;
		it.band_two = 16'hFFFF; it.band_three = 16'hFFFF;
		pending_items.push_back(it);
		pending_items.push_back(make_voice(1, 0));
		pending_items.push_back(make_voice(1, 500));
		pending_items.push_back(make_voice(2, 0));
		it = '0; it.utterance_length = 24'd7999;
		pending_items.push_back(it);
		it = make_voice(3, 0); it.override_valid = 1'b1; it.override_tag = 4'd15;
		pending_items.push_back(it);
		it = make_voice(3, 0); it.override_valid = 1'b1; it.override_tag = 4'd15;
		pending_items.push_back(it);
		it = '0; it.override_valid = 1'b1; it.override_tag = 4'd9;
		pending_items.push_back(it);
		it = '0; it.utterance_length = 24'd9000;
		pending_items.push_back(it);
		wait_drained();

		apb_write(spm_pkg::REG_MAX_SPK, 32'd0);
		apb_write(spm_pkg::REG_THRESHOLD, 32'd65536);
		apb_write(spm_pkg::REG_MIN_SAMP, 32'd0);
		it = make_voice(0, 0); it.utterance_length = '0;
		pending_items.push_back(it);
		pending_items.push_back(make_voice(2, 100));
		it = make_voice(1, 0); it.override_valid = 1'b1; it.override_tag = 4'd3;
		pending_items.push_back(it);
		wait_drained();

		apb_write(spm_pkg::REG_MAX_SPK, 32'd7);
		apb_write(spm_pkg::REG_THRESHOLD, 32'd0);
		apb_write(spm_pkg::REG_MIN_SAMP, 32'hFFFFFF);
		pending_items.push_back(make_voice(3, 0));
		it = make_voice(0, 0); it.override_valid = 1'b1; it.override_tag = 4'd0;
		pending_items.push_back(it);
		wait_drained();

		// random phases with different settings
		apb_write(spm_pkg::REG_MIN_SAMP, 32'd8000);
		apb_write(spm_pkg::REG_THRESHOLD, 32'd60000);
		apb_write(spm_pkg::REG_MAX_SPK, 32'd4);
		add_voices(250, 8);
		wait_drained();

		apb_write(spm_pkg::REG_THRESHOLD, 32'd64000);
		apb_write(spm_pkg::REG_MAX_SPK, 32'd1);
		add_voices(150, 15);
		hold_sender = 1'b1;
		while (expected_results.size() != 0 || in_valid) @(posedge clk);
		hold_sender = 1'b0;
		add_voices(100, 15);
		wait_drained();

		apb_write(spm_pkg::REG_THRESHOLD, 32'd49152);
		apb_write(spm_pkg::REG_MAX_SPK, 32'd3);
		apb_write(spm_pkg::REG_MIN_SAMP, 32'd100000);
		add_voices(280, 10);
		wait_drained();

		$display("ran %0d items, %0d results checked", n_sent, n_results);
		$display("outcomes: fallback %0d override %0d matched %0d enrolled %0d pinned %0d",
			outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3], outcome_seen[4]);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("timeout");
		$display("FAILED: results differ");
		$finish;
	end
endmodule
